[src/graph_multilist_traversal_macros.svh]
// Assertion macros for the graph traversal engine
`ifndef GRAPH_MULTILIST_TRAVERSAL_MACROS_SVH
`define GRAPH_MULTILIST_TRAVERSAL_MACROS_SVH
`ifndef SYNTHESIS
`define GMT_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define GMT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define GMT_ASSERT_ALWAYS(label, clk, rst, expr)
`define GMT_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

[src/gmt_pkg.sv]
// ----------------------------------------------------------------------------
// gmt_pkg
// Codes and sequencer states of the adjacency multilist traversal engine.
// ----------------------------------------------------------------------------
package gmt_pkg;

   localparam logic [1:0] ACT_ADD_VERTEX = 2'd0;
   localparam logic [1:0] ACT_ADD_EDGE   = 2'd1;
   localparam logic [1:0] ACT_DFS        = 2'd2;
   localparam logic [1:0] ACT_BFS        = 2'd3;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_UNKNOWN   = 3'd2;
   localparam logic [2:0] ST_EMPTY     = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   typedef enum logic [4:0] {
      S_IDLE,
      S_FIND_RD,
      S_FIND_CMP,
      S_DECIDE,
      S_E_RDA,
      S_E_RDB,
      S_E_WR,
      S_E_WR2,
      S_RESP,
      S_O_CHK,
      S_V_RD,
      S_V_EMIT,
      S_D_TOP,
      S_D_RD,
      S_D_CHK,
      S_D_ERD,
      S_D_EDGE,
      S_B_HEAD,
      S_B_RD,
      S_B_V,
      S_B_FRD,
      S_B_E,
      S_B_ECHK,
      S_B_ERD,
      S_B_EDGE,
      S_FLUSH
   } state_type;

endpackage

[src/graph_multilist_traversal.sv]
// ----------------------------------------------------------------------------
// graph_multilist_traversal
// Undirected graph engine on an adjacency multilist with DFS and BFS walks.
// ----------------------------------------------------------------------------
// Input transactions arrive on req_ (tuser = action, tdata = vertex_value then
// other_vertex). Results leave on rsp_ (tdata = visited_value, tuser = status,
// tlast = final result of the transaction). req_tready is high only while the
// sequencer is idle; one transaction is worked on at a time.
// Add vertex scans the vertex memory over every stored vertex, then
// answers. Add edge takes the same scan, then, when both ends are found and
// the edge table has room, reads both list heads and links the new edge entry.
// A traversal emits every stored vertex; the pace of each visit and each
// incidence list step is set by the single read port of each memory.
// Every edge sits on the lists of both its ends. An empty graph gives one status result.
// Results pass through one output register; while the receiver stalls, the
// sequencer holds at its next emit. One visited value is held back so that
// the final one can carry tlast.
// Reset empties the vertex and edge tables; memory contents are left as they
// are and are only read where written first. No clearing pass is needed.
// ----------------------------------------------------------------------------
module graph_multilist_traversal
   import gmt_pkg::*;
#(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_EDGES    = 64,
   parameter int VALUE_BITS   = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // vertex_value, other_vertex
   input  logic [((2*VALUE_BITS+7)/8)*8-1:0]        req_tdata,
   // action
   input  logic [1:0]                              req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // visited_value
   output logic [((VALUE_BITS+7)/8)*8-1:0]          rsp_tdata,
   // status
   output logic [2:0]                              rsp_tuser,
   output logic                                    rsp_tlast
);

`include "graph_multilist_traversal_macros.svh"

   localparam int VI  = $clog2(MAX_VERTICES);
   localparam int TW  = $clog2(MAX_VERTICES + 1);
   localparam int EA  = $clog2(MAX_EDGES);
   localparam int EW  = $clog2(MAX_EDGES + 1);
   localparam int ODW = ((VALUE_BITS + 7) / 8) * 8;
   localparam logic [EW-1:0] NO_EDGE = EW'(MAX_EDGES);
   localparam logic [TW-1:0] MV_C    = TW'(MAX_VERTICES);
   localparam logic [TW-1:0] ONE_T   = TW'(1);

   // memories
   logic [VALUE_BITS-1:0] vstore_mem [MAX_VERTICES];
   logic [EW-1:0]         fedge_mem  [MAX_VERTICES];
   logic [VI-1:0]         work_mem   [MAX_VERTICES];
   logic [EW-1:0]         cursor_mem [MAX_VERTICES];
   logic [VI-1:0]         enda_mem   [MAX_EDGES];
   logic [VI-1:0]         endb_mem   [MAX_EDGES];
   logic [EW-1:0]         nexta_mem  [MAX_EDGES];
   logic [EW-1:0]         nextb_mem  [MAX_EDGES];

   logic [VALUE_BITS-1:0] vs_rd_ff;
   logic [EW-1:0]         fe_rd_ff;
   logic [VI-1:0]         wk_rd_ff;
   logic [EW-1:0]         cu_rd_ff;
   logic [VI-1:0]         ea_rd_ff, eb_rd_ff;
   logic [EW-1:0]         na_rd_ff, nb_rd_ff;

   logic [VI-1:0] vs_addr, fe_addr, wk_addr, cu_addr;
   logic          vs_we, fe_we, wk_we, cu_we, ed_we;
   logic [VI-1:0] vs_waddr, fe_waddr, wk_waddr, cu_waddr;
   logic [VALUE_BITS-1:0] vs_wdata;
   logic [EW-1:0] fe_wdata, cu_wdata;
   logic [VI-1:0] wk_wdata;

   state_type state_ff, state_in;
   logic [1:0]            act_ff, act_in;
   logic [VALUE_BITS-1:0] va_ff, va_in, vb_ff, vb_in;
   logic [TW-1:0]         idx_ff, idx_in;
   logic                  fa_ok_ff, fa_ok_in, fb_ok_ff, fb_ok_in;
   logic [VI-1:0]         ia_ff, ia_in, ib_ff, ib_in;
   logic [TW-1:0]         vtot_ff, vtot_in;
   logic [EW-1:0]         etot_ff, etot_in;
   logic [EW-1:0]         fhead_ff, fhead_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic [TW-1:0]         oi_ff, oi_in;
   logic [VI-1:0]         vv_ff, vv_in, cur_ff, cur_in;
   logic [EW-1:0]         e_ff, e_in;
   logic [TW-1:0]         top_ff, top_in, head_ff, head_in, tail_ff, tail_in;
   logic                  pend_v_ff, pend_v_in;
   logic [VALUE_BITS-1:0] pend_ff, pend_in;
   logic [2:0]            res_st_ff, res_st_in;
   logic                  out_v_ff, out_v_in;
   logic [VALUE_BITS-1:0] out_val_ff, out_val_in;
   logic [2:0]            out_st_ff, out_st_in;
   logic                  out_last_ff, out_last_in;

   logic                  accept, out_free, emit_stall;
   logic [VI-1:0]         top_m1, j_v;
   logic [EW-1:0]         nxt_e;
   logic                  j_visited;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !out_v_ff || rsp_tready;
   assign emit_stall = pend_v_ff && !out_free;
   assign top_m1     = VI'(top_ff - ONE_T);
   assign j_v        = (ea_rd_ff == cur_ff) ? eb_rd_ff : ea_rd_ff;
   assign nxt_e      = (ea_rd_ff == cur_ff) ? na_rd_ff : nb_rd_ff;
   assign j_visited  = visited_ff[j_v];

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = ODW'(out_val_ff);
   assign rsp_tuser  = out_st_ff;
   assign rsp_tlast  = out_last_ff;

   // read addresses
   always_comb begin
      vs_addr = (state_ff == S_FIND_RD || state_ff == S_FIND_CMP) ? idx_ff[VI-1:0] : vv_ff;
      case (state_ff)
         S_E_RDA:         fe_addr = ia_ff;
         S_E_RDB, S_E_WR: fe_addr = ib_ff;
         S_B_FRD, S_B_E:  fe_addr = cur_ff;
         default:         fe_addr = vv_ff;
      endcase
      wk_addr = (state_ff == S_D_RD || state_ff == S_D_CHK) ? top_m1 : head_ff[VI-1:0];
      cu_addr = top_m1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == ACT_ADD_VERTEX || req_tuser == ACT_ADD_EDGE) begin
                  state_in = S_FIND_RD;
               end else if (vtot_ff == '0) begin
                  state_in = S_RESP;
               end else begin
                  state_in = S_O_CHK;
               end
            end
         end
         S_FIND_RD:  state_in = (idx_ff == vtot_ff) ? S_DECIDE : S_FIND_CMP;
         S_FIND_CMP: state_in = S_FIND_RD;
         S_DECIDE: begin
            if (act_ff == ACT_ADD_EDGE && fa_ok_ff && fb_ok_ff && etot_ff < NO_EDGE) begin
               state_in = S_E_RDA;
            end else begin
               state_in = S_RESP;
            end
         end
         S_E_RDA: state_in = S_E_RDB;
         S_E_RDB: state_in = S_E_WR;
         S_E_WR:  state_in = S_E_WR2;
         S_E_WR2: state_in = S_RESP;
         S_RESP:  state_in = out_free ? S_IDLE : S_RESP;
         S_O_CHK: begin
            if (oi_ff == vtot_ff) begin
               state_in = S_FLUSH;
            end else if (!visited_ff[oi_ff[VI-1:0]]) begin
               state_in = S_V_RD;
            end
         end
         S_V_RD: state_in = S_V_EMIT;
         S_V_EMIT: begin
            if (!emit_stall) begin
               state_in = (act_ff == ACT_DFS) ? S_D_TOP : S_B_ECHK;
            end
         end
         S_D_TOP: state_in = (top_ff == '0) ? S_O_CHK : S_D_RD;
         S_D_RD:  state_in = S_D_CHK;
         S_D_CHK: state_in = (cu_rd_ff >= NO_EDGE) ? S_D_TOP : S_D_ERD;
         S_D_ERD: state_in = S_D_EDGE;
         S_D_EDGE: state_in = (!j_visited && top_ff < MV_C) ? S_V_RD : S_D_TOP;
         S_B_HEAD: state_in = (head_ff == tail_ff) ? S_O_CHK : S_B_RD;
         S_B_RD:   state_in = S_B_V;
         S_B_V:    state_in = S_B_FRD;
         S_B_FRD:  state_in = S_B_E;
         S_B_E:    state_in = S_B_ECHK;
         S_B_ECHK: state_in = (e_ff >= NO_EDGE) ? S_B_HEAD : S_B_ERD;
         S_B_ERD:  state_in = S_B_EDGE;
         S_B_EDGE: state_in = (!j_visited && tail_ff < MV_C) ? S_V_RD : S_B_ECHK;
         S_FLUSH:  state_in = out_free ? S_IDLE : S_FLUSH;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      act_in = act_ff; va_in = va_ff; vb_in = vb_ff; idx_in = idx_ff;
      fa_ok_in = fa_ok_ff; fb_ok_in = fb_ok_ff; ia_in = ia_ff; ib_in = ib_ff;
      vtot_in = vtot_ff; etot_in = etot_ff; fhead_in = fhead_ff;
      visited_in = visited_ff; oi_in = oi_ff; vv_in = vv_ff; cur_in = cur_ff;
      e_in = e_ff; top_in = top_ff; head_in = head_ff; tail_in = tail_ff;
      pend_v_in = pend_v_ff; pend_in = pend_ff; res_st_in = res_st_ff;
      out_v_in = out_v_ff && !rsp_tready;
      out_val_in = out_val_ff; out_st_in = out_st_ff; out_last_in = out_last_ff;
      vs_we = 1'b0; vs_waddr = vtot_ff[VI-1:0]; vs_wdata = va_ff;
      fe_we = 1'b0; fe_waddr = vtot_ff[VI-1:0]; fe_wdata = NO_EDGE;
      wk_we = 1'b0; wk_waddr = top_ff[VI-1:0]; wk_wdata = vv_ff;
      cu_we = 1'b0; cu_waddr = top_ff[VI-1:0]; cu_wdata = fe_rd_ff;
      ed_we = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in   = req_tuser;
               va_in    = req_tdata[VALUE_BITS-1:0];
               vb_in    = req_tdata[2*VALUE_BITS-1:VALUE_BITS];
               idx_in   = '0;
               fa_ok_in = 1'b0;
               fb_ok_in = 1'b0;
               oi_in    = '0;
               res_st_in = ST_EMPTY;
               visited_in = '0;
            end
         end
         S_FIND_CMP: begin
            if (!fa_ok_ff && vs_rd_ff == va_ff) begin
               fa_ok_in = 1'b1;
               ia_in    = idx_ff[VI-1:0];
            end
            if (!fb_ok_ff && vs_rd_ff == vb_ff) begin
               fb_ok_in = 1'b1;
               ib_in    = idx_ff[VI-1:0];
            end
            idx_in = idx_ff + ONE_T;
         end
         S_DECIDE: begin
            if (act_ff == ACT_ADD_VERTEX) begin
               if (fa_ok_ff) begin
                  res_st_in = ST_DUPLICATE;
               end else if (vtot_ff >= MV_C) begin
                  res_st_in = ST_FULL;
               end else begin
                  vs_we = 1'b1;
                  fe_we = 1'b1;
                  visited_in[vtot_ff[VI-1:0]] = 1'b0;
                  vtot_in   = vtot_ff + ONE_T;
                  res_st_in = ST_OK;
               end
            end else if (!fa_ok_ff || !fb_ok_ff) begin
               res_st_in = ST_UNKNOWN;
            end else if (etot_ff >= NO_EDGE) begin
               res_st_in = ST_FULL;
            end else begin
               res_st_in = ST_OK;
            end
         end
         S_E_RDB: fhead_in = fe_rd_ff;
         S_E_WR: begin
            ed_we    = 1'b1;
            fe_we    = 1'b1;
            fe_waddr = ia_ff;
            fe_wdata = etot_ff;
         end
         S_E_WR2: begin
            fe_we    = 1'b1;
            fe_waddr = ib_ff;
            fe_wdata = etot_ff;
            etot_in  = etot_ff + EW'(1);
         end
         S_RESP: begin
            if (out_free) begin
               out_v_in    = 1'b1;
               out_val_in  = '0;
               out_st_in   = res_st_ff;
               out_last_in = 1'b1;
            end
         end
         S_O_CHK: begin
            if (oi_ff != vtot_ff) begin
               if (!visited_ff[oi_ff[VI-1:0]]) begin
                  vv_in   = oi_ff[VI-1:0];
                  top_in  = '0;
                  head_in = '0;
                  tail_in = '0;
                  e_in    = NO_EDGE;
               end
               oi_in = oi_ff + ONE_T;
            end
         end
         S_V_EMIT: begin
            if (!emit_stall) begin
               if (pend_v_ff) begin
                  out_v_in    = 1'b1;
                  out_val_in  = pend_ff;
                  out_st_in   = ST_OK;
                  out_last_in = 1'b0;
               end
               pend_v_in = 1'b1;
               pend_in   = vs_rd_ff;
               visited_in[vv_ff] = 1'b1;
               wk_we = 1'b1;
               if (act_ff == ACT_DFS) begin
                  cu_we  = 1'b1;
                  top_in = top_ff + ONE_T;
               end else begin
                  wk_waddr = tail_ff[VI-1:0];
                  tail_in  = tail_ff + ONE_T;
               end
            end
         end
         S_D_CHK: begin
            cur_in = wk_rd_ff;
            if (cu_rd_ff >= NO_EDGE) begin
               top_in = top_ff - ONE_T;
            end else begin
               e_in = cu_rd_ff;
            end
         end
         S_D_EDGE: begin
            cu_we    = 1'b1;
            cu_waddr = top_m1;
            cu_wdata = nxt_e;
            vv_in    = j_v;
         end
         S_B_V: begin
            cur_in  = wk_rd_ff;
            head_in = head_ff + ONE_T;
         end
         S_B_E: e_in = fe_rd_ff;
         S_B_EDGE: begin
            e_in  = nxt_e;
            vv_in = j_v;
         end
         S_FLUSH: begin
            if (out_free) begin
               out_v_in    = 1'b1;
               out_val_in  = pend_ff;
               out_st_in   = ST_OK;
               out_last_in = 1'b1;
               pend_v_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         vtot_ff    <= '0;
         etot_ff    <= '0;
         visited_ff <= '0;
         pend_v_ff  <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         vtot_ff    <= vtot_in;
         etot_ff    <= etot_in;
         visited_ff <= visited_in;
         pend_v_ff  <= pend_v_in;
         out_v_ff   <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in; va_ff <= va_in; vb_ff <= vb_in; idx_ff <= idx_in;
      fa_ok_ff <= fa_ok_in; fb_ok_ff <= fb_ok_in; ia_ff <= ia_in; ib_ff <= ib_in;
      fhead_ff <= fhead_in; oi_ff <= oi_in; vv_ff <= vv_in; cur_ff <= cur_in;
      e_ff <= e_in; top_ff <= top_in; head_ff <= head_in; tail_ff <= tail_in;
      pend_ff <= pend_in; res_st_ff <= res_st_in;
      out_val_ff <= out_val_in; out_st_ff <= out_st_in; out_last_ff <= out_last_in;
   end

   // vertex side memories
   always_ff @(posedge clock) begin
      if (vs_we) begin
         vstore_mem[vs_waddr] <= vs_wdata;
      end
      vs_rd_ff <= vstore_mem[vs_addr];
   end

   always_ff @(posedge clock) begin
      if (fe_we) begin
         fedge_mem[fe_waddr] <= fe_wdata;
      end
      fe_rd_ff <= fedge_mem[fe_addr];
   end

   always_ff @(posedge clock) begin
      if (wk_we) begin
         work_mem[wk_waddr] <= wk_wdata;
      end
      wk_rd_ff <= work_mem[wk_addr];
   end

   always_ff @(posedge clock) begin
      if (cu_we) begin
         cursor_mem[cu_waddr] <= cu_wdata;
      end
      cu_rd_ff <= cursor_mem[cu_addr];
   end

   // edge record memory: both next links take the old list heads
   always_ff @(posedge clock) begin
      if (ed_we) begin
         enda_mem[etot_ff[EA-1:0]]  <= ia_ff;
         endb_mem[etot_ff[EA-1:0]]  <= ib_ff;
         nexta_mem[etot_ff[EA-1:0]] <= fhead_ff;
         nextb_mem[etot_ff[EA-1:0]] <= fe_rd_ff;
      end
      ea_rd_ff <= enda_mem[e_ff[EA-1:0]];
      eb_rd_ff <= endb_mem[e_ff[EA-1:0]];
      na_rd_ff <= nexta_mem[e_ff[EA-1:0]];
      nb_rd_ff <= nextb_mem[e_ff[EA-1:0]];
   end

   `GMT_ASSERT_ALWAYS(a_vtot_range, clock, reset, vtot_ff <= MV_C)
   `GMT_ASSERT_ALWAYS(a_etot_range, clock, reset, etot_ff <= NO_EDGE)
   `GMT_ASSERT_ALWAYS(a_flush_pend, clock, reset, (state_ff != S_FLUSH) || pend_v_ff)
   `GMT_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready)

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the adjacency multilist traversal engine. Mixes
// vertex and edge insertions with depth-first and breadth-first walks, predicts
// every visited value and status, and compares each result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
   import gmt_pkg::*;
();

   localparam int NV = 32;
   localparam int NE = 64;
   localparam int LIMIT = 2000000;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] va;
      logic [15:0] vb;
   } graph_op_type;

   typedef struct packed {
      logic [15:0] value;
      logic [2:0]  status;
      logic        last;
   } walk_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = ACT_ADD_VERTEX;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   graph_multilist_traversal uut (.*);

   // predictor state
   logic [15:0] vstore [NV];
   int          vcount;
   int          ehead [NV];
   int          ea [NE], eb [NE], na [NE], nb [NE];
   int          ecount;
   bit          seen [NV];
   int          wlist [NV], cur [NV];

   graph_op_type    pending_ops [$];
   walk_result_type expected_results [$];
   int errors = 0, ops_sent = 0, results_seen = 0, walks = 0;
   int cycles = 0;

   initial forever #5 clock = ~clock;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout at %0t", $time);
         $display("graph_multilist_traversal: mismatch");
         $finish;
      end
   end

   function automatic int find_vertex(logic [15:0] v);
      for (int i = 0; i < vcount; i++) if (vstore[i] == v) return i;
      return -1;
   endfunction

   function automatic void push_result(logic [15:0] v, logic [2:0] s, logic l);
      walk_result_type r;
      r.value = v; r.status = s; r.last = l;
      expected_results.push_back(r);
   endfunction

   function automatic int far_end(int e, int v);
      return (ea[e] == v) ? eb[e] : ea[e];
   endfunction

   function automatic int next_link(int e, int v);
      return (ea[e] == v) ? na[e] : nb[e];
   endfunction

   function automatic void mark(int v);
      seen[v] = 1;
      push_result(vstore[v], ST_OK, 1'b0);
   endfunction

   function automatic void predict_op(graph_op_type op);
      int ia, ib, top, lvl, v, e, j, head, tail;
      case (op.action)
         ACT_ADD_VERTEX: begin
            if (find_vertex(op.va) >= 0) push_result('0, ST_DUPLICATE, 1'b1);
            else if (vcount >= NV) push_result('0, ST_FULL, 1'b1);
            else begin
               vstore[vcount] = op.va; ehead[vcount] = NE; vcount++;
               push_result('0, ST_OK, 1'b1);
            end
         end
         ACT_ADD_EDGE: begin
            ia = find_vertex(op.va);
            ib = find_vertex(op.vb);
            if (ia < 0 || ib < 0) push_result('0, ST_UNKNOWN, 1'b1);
            else if (ecount >= NE) push_result('0, ST_FULL, 1'b1);
            else begin
               ea[ecount] = ia; eb[ecount] = ib;
               na[ecount] = ehead[ia]; nb[ecount] = ehead[ib];
               ehead[ia] = ecount; ehead[ib] = ecount;
               ecount++;
               push_result('0, ST_OK, 1'b1);
            end
         end
         default: begin
            if (vcount == 0) begin
               push_result('0, ST_EMPTY, 1'b1);
               return;
            end
            for (int i = 0; i < vcount; i++) seen[i] = 0;
            for (int s = 0; s < vcount; s++) begin
               if (seen[s]) continue;
               mark(s);
               if (op.action == ACT_DFS) begin
                  wlist[0] = s; cur[0] = ehead[s]; top = 1;
                  while (top > 0) begin
                     lvl = top - 1; v = wlist[lvl]; e = cur[lvl];
                     if (e >= NE) begin
                        top--;
                        continue;
                     end
                     j = far_end(e, v);
                     cur[lvl] = next_link(e, v);
                     if (!seen[j] && top < NV) begin
                        mark(j);
                        wlist[top] = j; cur[top] = ehead[j]; top++;
                     end
                  end
               end else begin
                  head = 0; tail = 1; wlist[0] = s;
                  while (head < tail) begin
                     v = wlist[head++]; e = ehead[v];
                     while (e < NE) begin
                        j = far_end(e, v);
                        if (!seen[j] && tail < NV) begin
                           mark(j);
                           wlist[tail++] = j;
                        end
                        e = next_link(e, v);
                     end
                  end
               end
            end
            expected_results[$].last = 1'b1;
         end
      endcase
   endfunction

   // accepted request seen at the rising edge, used by the driver afterwards
   logic req_fire = 1'b0;
   always @(posedge clock) req_fire <= req_tvalid && req_tready;

   // driver
   int           req_gap = 0;
   graph_op_type cur_op;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_fire) begin
            ops_sent <= ops_sent + 1;
            req_gap = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) req_gap = 0;
            req_tvalid <= 1'b0;
         end else if (!req_tvalid) begin
            if (req_gap > 0) req_gap--;
            else if (pending_ops.size() > 0) begin
               cur_op = pending_ops.pop_front();
               predict_op(cur_op);
               req_tuser  <= cur_op.action;
               req_tdata  <= {cur_op.vb, cur_op.va};
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // receiver stalls and monitor
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            if (rsp_tvalid && rsp_tready && $urandom_range(0, 2) == 0)
               rsp_gap = $urandom_range(0, 6);
            rsp_tready <= (rsp_gap == 0);
         end
      end
   end

   always @(posedge clock) begin
      walk_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result value=%h status=%0d last=%b", $time,
                     rsp_tdata, rsp_tuser, rsp_tlast);
            errors <= errors + 1;
         end else begin
            want = expected_results.pop_front();
            if (want.value !== rsp_tdata || want.status !== rsp_tuser ||
                want.last !== rsp_tlast) begin
               $display("%0t: expected value=%h status=%0d last=%b, got value=%h status=%0d last=%b",
                        $time, want.value, want.status, want.last,
                        rsp_tdata, rsp_tuser, rsp_tlast);
               errors <= errors + 1;
            end
         end
      end
   end

   function automatic void queue_op(logic [1:0] a, logic [15:0] x, logic [15:0] y);
      graph_op_type op;
      op.action = a; op.va = x; op.vb = y;
      pending_ops.push_back(op);
      if (a == ACT_DFS || a == ACT_BFS) walks++;
   endfunction

   function automatic logic [15:0] pick_value(logic [15:0] pool [$]);
      if (pool.size() == 0 || $urandom_range(0, 9) == 0) return 16'($urandom);
      return pool[$urandom_range(0, pool.size() - 1)];
   endfunction

   initial begin
      vcount = 0;
      ecount = 0;
      // directed: empty walks, extremes, duplicates, unknowns, self loop
      queue_op(ACT_DFS, 16'h0, 16'h0);
      queue_op(ACT_BFS, 16'h0, 16'h0);
      queue_op(ACT_ADD_EDGE, 16'h1, 16'h2);
      queue_op(ACT_ADD_VERTEX, 16'h8000, 16'hFFFF);
      queue_op(ACT_ADD_VERTEX, 16'h7FFF, 16'h0);
      queue_op(ACT_ADD_VERTEX, 16'hFFFF, 16'h0);
      queue_op(ACT_ADD_VERTEX, 16'h0000, 16'h0);
      queue_op(ACT_ADD_VERTEX, 16'h8000, 16'h0);
      queue_op(ACT_ADD_EDGE, 16'h8000, 16'h7FFF);
      queue_op(ACT_ADD_EDGE, 16'h7FFF, 16'h7FFF);
      queue_op(ACT_ADD_EDGE, 16'hFFFF, 16'h1234);
      queue_op(ACT_ADD_EDGE, 16'h5555, 16'h0000);
      queue_op(ACT_ADD_EDGE, 16'h0000, 16'h8000);
      queue_op(ACT_DFS, 16'hFFFF, 16'hFFFF);
      queue_op(ACT_BFS, 16'hAAAA, 16'h5555);
      // fill the vertex table to overflow; the edge table ends with 60 of its 64 entries
      for (int i = 0; i < 30; i++) queue_op(ACT_ADD_VERTEX, 16'(i * 97 + 3), 16'h0);
      for (int i = 0; i < 66; i++)
         queue_op(ACT_ADD_EDGE, 16'((i % 30) * 97 + 3), 16'(((i * 7) % 30) * 97 + 3));
      queue_op(ACT_DFS, 16'h0, 16'h0);
      queue_op(ACT_BFS, 16'h0, 16'h0);
      reset_and_go();
   end

   task automatic reset_and_go();
      logic [15:0] pool [$];
      int nv, ne;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // random graphs built on top; the vertex table is already full, so later
      // phases see mostly refusals. Reset is not repeated: instead the small
      // graphs are told apart by fresh random values.
      wait (pending_ops.size() == 0 && expected_results.size() == 0);
      for (int g = 0; g < 12; g++) begin
         pool.delete();
         nv = $urandom_range(1, 8);
         for (int i = 0; i < nv; i++) begin
            pool.push_back(16'($urandom));
            queue_op(ACT_ADD_VERTEX, pool[$], 16'($urandom));
         end
         ne = $urandom_range(0, 10);
         for (int i = 0; i < ne; i++) queue_op(ACT_ADD_EDGE, pick_value(pool), pick_value(pool));
         for (int i = 0; i < 8; i++)
            queue_op($urandom_range(0, 1) ? ACT_DFS : ACT_BFS, 16'($urandom), 16'($urandom));
         if ($urandom_range(0, 1)) queue_op(2'($urandom), pick_value(pool), pick_value(pool));
      end
      while (pending_ops.size() + ops_sent < 470)
         queue_op(2'($urandom), 16'($urandom), 16'($urandom));
      wait (pending_ops.size() == 0 && !req_tvalid && expected_results.size() == 0);
      repeat (200) @(posedge clock);
      $display("Sent %0d requests including %0d walks; checked %0d results.",
               ops_sent, walks, results_seen);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("graph_multilist_traversal: match");
      end else begin
         $display("graph_multilist_traversal: mismatch");
      end
      $finish;
   endtask

endmodule
